// ===== rtl/cllfl_pkg.sv =====
// ----------------------------------------------------------------------------
// cllfl_pkg
// Shared widths, datapath operation codes and status bundle for the cursor
// list with free list.
// ----------------------------------------------------------------------------
package cllfl_pkg;

  localparam int unsigned ID_W   = 31;
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned SEX_W  = 8;
  localparam int unsigned SLOT_W = 4;

  // Operations the controller issues to the datapath, one per cycle
  typedef enum logic [3:0] {
    DP_NOP,
    DP_INIT,
    DP_LOAD,
    DP_INS_RD,
    DP_INS_LINK,
    DP_WALK_RD,
    DP_WALK_ADV,
    DP_RM_UNLINK,
    DP_RM_FREE,
    DP_FAIL
  } dp_op_e;

  typedef struct packed {
    logic init_last;
    logic pool_full;
    logic list_empty;
    logic name_match;
    logic walk_last;
  } dp_status_t;

endpackage

// ===== rtl/cllfl_ctrl.sv =====
// ----------------------------------------------------------------------------
// cllfl_ctrl
// Sequencer: free list building pass, insert, list walk and unlink. Drives one
// datapath operation per cycle, plus busy and the result strobe.
// ----------------------------------------------------------------------------
module cllfl_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  action_i,
  input  cllfl_pkg::dp_status_t status_i,
  output cllfl_pkg::dp_op_e     op_o,
  output logic                  busy_o,
  output logic                  done_o
);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_FAIL,
    ST_INS_RD,
    ST_INS_LINK,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_RM_UNLINK,
    ST_RM_FREE
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  always_comb begin
    unique case (state_q)
      ST_INIT:      op_o = cllfl_pkg::DP_INIT;
      ST_IDLE:      op_o = start_i ? cllfl_pkg::DP_LOAD : cllfl_pkg::DP_NOP;
      ST_FAIL:      op_o = cllfl_pkg::DP_FAIL;
      ST_INS_RD:    op_o = cllfl_pkg::DP_INS_RD;
      ST_INS_LINK:  op_o = cllfl_pkg::DP_INS_LINK;
      ST_WALK_RD:   op_o = cllfl_pkg::DP_WALK_RD;
      ST_WALK_CHK:  op_o = status_i.name_match ? cllfl_pkg::DP_NOP : cllfl_pkg::DP_WALK_ADV;
      ST_RM_UNLINK: op_o = cllfl_pkg::DP_RM_UNLINK;
      ST_RM_FREE:   op_o = cllfl_pkg::DP_RM_FREE;
      default:      op_o = cllfl_pkg::DP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      // strobe follows the last cycle of every transfer
      done_q <= (state_q == ST_FAIL) || (state_q == ST_INS_LINK) ||
                (state_q == ST_RM_FREE);
      unique case (state_q)
        ST_INIT: begin
          if (status_i.init_last) begin
            state_q <= ST_IDLE;
            busy_q  <= 1'b0;
          end
        end
        ST_IDLE: begin
          if (start_i) begin
            busy_q <= 1'b1;
            if (!action_i) begin
              state_q <= status_i.pool_full ? ST_FAIL : ST_INS_RD;
            end else begin
              state_q <= status_i.list_empty ? ST_FAIL : ST_WALK_RD;
            end
          end
        end
        ST_INS_RD:    state_q <= ST_INS_LINK;
        ST_WALK_RD:   state_q <= ST_WALK_CHK;
        ST_WALK_CHK: begin
          if (status_i.name_match) begin
            state_q <= ST_RM_UNLINK;
          end else if (status_i.walk_last) begin
            state_q <= ST_FAIL;
          end else begin
            state_q <= ST_WALK_RD;
          end
        end
        ST_RM_UNLINK: state_q <= ST_RM_FREE;
        ST_FAIL, ST_INS_LINK, ST_RM_FREE: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

// ===== rtl/cllfl_dp.sv =====
// ----------------------------------------------------------------------------
// cllfl_dp
// Record pool and link memories, list and free heads, walk cursors, item
// capture and result registers.
// ----------------------------------------------------------------------------
module cllfl_dp #(
  parameter int unsigned POOL_SLOTS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cllfl_pkg::dp_op_e                  op_i,
  input  logic [cllfl_pkg::ID_W-1:0]         stud_id_i,
  input  logic [cllfl_pkg::KEY_W-1:0]        name_key_i,
  input  logic [cllfl_pkg::SEX_W-1:0]        sex_code_i,
  input  logic [cllfl_pkg::KEY_W-1:0]        program_key_i,
  output cllfl_pkg::dp_status_t              status_o,
  output logic                               ok_o,
  output logic [cllfl_pkg::SLOT_W-1:0]       slot_o,
  output logic [cllfl_pkg::ID_W-1:0]         out_id_o,
  output logic [cllfl_pkg::KEY_W-1:0]        out_name_o,
  output logic [cllfl_pkg::SEX_W-1:0]        out_sex_o,
  output logic [cllfl_pkg::KEY_W-1:0]        out_program_o
);

  localparam int unsigned IDX_W  = $clog2(POOL_SLOTS);
  localparam int unsigned LINK_W = $clog2(POOL_SLOTS + 1);
  localparam int unsigned EXT_W  = IDX_W + cllfl_pkg::SLOT_W;
  // a link equal to the pool size names no slot
  localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_SLOTS);

  logic [LINK_W-1:0]              link_mem [POOL_SLOTS];
  logic [cllfl_pkg::ID_W-1:0]     id_mem   [POOL_SLOTS];
  logic [cllfl_pkg::KEY_W-1:0]    name_mem [POOL_SLOTS];
  logic [cllfl_pkg::SEX_W-1:0]    sex_mem  [POOL_SLOTS];
  logic [cllfl_pkg::KEY_W-1:0]    prog_mem [POOL_SLOTS];

  logic [LINK_W-1:0] list_head_q, free_head_q, cur_q, prev_q, steps_q;
  logic [IDX_W-1:0]  init_idx_q;

  logic [cllfl_pkg::KEY_W-1:0] key_q, prog_q;
  logic [cllfl_pkg::ID_W-1:0]  id_q;
  logic [cllfl_pkg::SEX_W-1:0] sex_q;

  logic [LINK_W-1:0]           rd_link_q;
  logic [cllfl_pkg::ID_W-1:0]  rd_id_q;
  logic [cllfl_pkg::KEY_W-1:0] rd_name_q, rd_prog_q;
  logic [cllfl_pkg::SEX_W-1:0] rd_sex_q;

  logic                          ok_q;
  logic [cllfl_pkg::SLOT_W-1:0]  slot_q;
  logic [cllfl_pkg::ID_W-1:0]    oid_q;
  logic [cllfl_pkg::KEY_W-1:0]   oname_q, oprog_q;
  logic [cllfl_pkg::SEX_W-1:0]   osex_q;

  logic              lnk_we;
  logic [IDX_W-1:0]  lnk_waddr;
  logic [LINK_W-1:0] lnk_wdata;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  free_idx, cur_idx;
  logic [EXT_W-1:0]  free_ext, cur_ext;

  assign free_idx = free_head_q[IDX_W-1:0];
  assign cur_idx  = cur_q[IDX_W-1:0];
  // slot port carries the low four bits of the index
  assign free_ext = EXT_W'(free_idx);
  assign cur_ext  = EXT_W'(cur_idx);

  always_comb begin
    lnk_we    = 1'b0;
    lnk_waddr = cur_idx;
    lnk_wdata = free_head_q;
    unique case (op_i)
      cllfl_pkg::DP_INIT: begin
        lnk_we    = 1'b1;
        lnk_waddr = init_idx_q;
        lnk_wdata = (init_idx_q == '0) ? NIL : LINK_W'(init_idx_q) - LINK_W'(1);
      end
      cllfl_pkg::DP_INS_LINK: begin
        lnk_we    = 1'b1;
        lnk_waddr = free_idx;
        lnk_wdata = list_head_q;
      end
      cllfl_pkg::DP_RM_UNLINK: begin
        lnk_we    = (prev_q != NIL);
        lnk_waddr = prev_q[IDX_W-1:0];
        lnk_wdata = rd_link_q;
      end
      cllfl_pkg::DP_RM_FREE: begin
        lnk_we    = 1'b1;
        lnk_waddr = cur_idx;
        lnk_wdata = free_head_q;
      end
      default: ;
    endcase
  end

  assign rd_en   = (op_i == cllfl_pkg::DP_INS_RD) || (op_i == cllfl_pkg::DP_WALK_RD);
  assign rd_addr = (op_i == cllfl_pkg::DP_INS_RD) ? free_idx : cur_idx;

  always_ff @(posedge clk_i) begin
    if (lnk_we) begin
      link_mem[lnk_waddr] <= lnk_wdata;
    end
    if (rd_en) begin
      rd_link_q <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == cllfl_pkg::DP_INS_RD) begin
      id_mem[free_idx]   <= id_q;
      name_mem[free_idx] <= key_q;
      sex_mem[free_idx]  <= sex_q;
      prog_mem[free_idx] <= prog_q;
    end
    if (op_i == cllfl_pkg::DP_WALK_RD) begin
      rd_id_q   <= id_mem[cur_idx];
      rd_name_q <= name_mem[cur_idx];
      rd_sex_q  <= sex_mem[cur_idx];
      rd_prog_q <= prog_mem[cur_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_head_q <= NIL;
      free_head_q <= LINK_W'(POOL_SLOTS - 1);
      cur_q       <= NIL;
      prev_q      <= NIL;
      steps_q     <= '0;
      init_idx_q  <= '0;
    end else begin
      unique case (op_i)
        cllfl_pkg::DP_INIT: init_idx_q <= init_idx_q + 1'b1;
        cllfl_pkg::DP_LOAD: begin
          cur_q   <= list_head_q;
          prev_q  <= NIL;
          steps_q <= '0;
        end
        cllfl_pkg::DP_INS_LINK: begin
          free_head_q <= rd_link_q;
          list_head_q <= free_head_q;
        end
        cllfl_pkg::DP_WALK_ADV: begin
          prev_q  <= cur_q;
          cur_q   <= rd_link_q;
          steps_q <= steps_q + 1'b1;
        end
        cllfl_pkg::DP_RM_UNLINK: begin
          if (prev_q == NIL) begin
            list_head_q <= rd_link_q;
          end
        end
        cllfl_pkg::DP_RM_FREE: free_head_q <= cur_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      cllfl_pkg::DP_LOAD: begin
        key_q  <= name_key_i;
        id_q   <= stud_id_i;
        sex_q  <= sex_code_i;
        prog_q <= program_key_i;
      end
      cllfl_pkg::DP_INS_LINK: begin
        ok_q    <= 1'b1;
        slot_q  <= free_ext[cllfl_pkg::SLOT_W-1:0];
        oid_q   <= '0;
        oname_q <= '0;
        osex_q  <= '0;
        oprog_q <= '0;
      end
      cllfl_pkg::DP_RM_FREE: begin
        ok_q    <= 1'b1;
        slot_q  <= cur_ext[cllfl_pkg::SLOT_W-1:0];
        oid_q   <= rd_id_q;
        oname_q <= rd_name_q;
        osex_q  <= rd_sex_q;
        oprog_q <= rd_prog_q;
      end
      cllfl_pkg::DP_FAIL: begin
        ok_q    <= 1'b0;
        slot_q  <= '0;
        oid_q   <= '0;
        oname_q <= '0;
        osex_q  <= '0;
        oprog_q <= '0;
      end
      default: ;
    endcase
  end

  assign status_o.init_last  = (init_idx_q == IDX_W'(POOL_SLOTS - 1));
  assign status_o.pool_full  = (free_head_q >= NIL);
  assign status_o.list_empty = (list_head_q >= NIL);
  assign status_o.name_match = (rd_name_q == key_q);
  // node just checked was the last one: end of list or walk bound reached
  assign status_o.walk_last  = (rd_link_q >= NIL) || (steps_q == LINK_W'(POOL_SLOTS - 1));

  assign ok_o          = ok_q;
  assign slot_o        = slot_q;
  assign out_id_o      = oid_q;
  assign out_name_o    = oname_q;
  assign out_sex_o     = osex_q;
  assign out_program_o = oprog_q;

  a_free_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == cllfl_pkg::DP_RM_FREE) |=> (free_head_q == $past(cur_q)))
    else $error("freed slot not at free list head");

  a_ins_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == cllfl_pkg::DP_INS_LINK) |=> (list_head_q == $past(free_head_q)))
    else $error("inserted slot not at list head");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == cllfl_pkg::DP_FAIL) |=> (!ok_q && (slot_q == '0) && (oname_q == '0)))
    else $error("failed transfer carries non-zero result");

  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (steps_q <= NIL))
    else $error("walk ran past pool size");

endmodule

// ===== rtl/cursor_list_with_free_list_core.sv =====
// ----------------------------------------------------------------------------
// cursor_list_with_free_list_core
// Record pool linked by index cursors, with a free list. Insert pushes a
// record at the list front; remove unlinks the first record matching a name.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  command   start & !busy      action, stud_id, name_key, sex_code, program_key
//  result    done_o (1 cycle)   ok, slot, out_id, out_name, out_sex, out_program
//
//  Insert: INS_RD, then INS_LINK; the strobe follows INS_LINK. Remove:
//  WALK_RD and WALK_CHK per node visited, then RM_UNLINK and RM_FREE on a
//  match, else FAIL; the link/name read is registered. An empty list (remove)
//  or full pool (insert) fails. After reset busy stays high while the link
//  memory is initialised. The receiver cannot stall; each result is shown once.
// ----------------------------------------------------------------------------
module cursor_list_with_free_list_core #(
  parameter int unsigned POOL_SLOTS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action_i,
  input  logic [cllfl_pkg::ID_W-1:0]    stud_id_i,
  input  logic [cllfl_pkg::KEY_W-1:0]   name_key_i,
  input  logic [cllfl_pkg::SEX_W-1:0]   sex_code_i,
  input  logic [cllfl_pkg::KEY_W-1:0]   program_key_i,
  output logic                          done_o,
  output logic                          ok_o,
  output logic [cllfl_pkg::SLOT_W-1:0]  slot_o,
  output logic [cllfl_pkg::ID_W-1:0]    out_id_o,
  output logic [cllfl_pkg::KEY_W-1:0]   out_name_o,
  output logic [cllfl_pkg::SEX_W-1:0]   out_sex_o,
  output logic [cllfl_pkg::KEY_W-1:0]   out_program_o
);

  cllfl_pkg::dp_op_e     op;
  cllfl_pkg::dp_status_t status;

  cllfl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .action_i (action_i),
    .status_i (status),
    .op_o     (op),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  cllfl_dp #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .stud_id_i     (stud_id_i),
    .name_key_i    (name_key_i),
    .sex_code_i    (sex_code_i),
    .program_key_i (program_key_i),
    .status_o      (status),
    .ok_o          (ok_o),
    .slot_o        (slot_o),
    .out_id_o      (out_id_o),
    .out_name_o    (out_name_o),
    .out_sex_o     (out_sex_o),
    .out_program_o (out_program_o)
  );

endmodule
